@@ rtl/ils_pkg.sv @@
`timescale 1ns / 1ps

package ils_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int MODE_W       = 3;
  localparam int CAPACITY_DEF = 64;

  // Operation codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_GET      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP     = 3'd4;

  // One result request from the sequencer to the output register
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic              ok;
    logic              last;
  } res_t;

endpackage

@@ rtl/ils_ram.sv @@
`timescale 1ns / 1ps

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ils_seq.sv @@
`timescale 1ns / 1ps

module ils_seq #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ils_pkg::MODE_W-1:0]  in_mode,
  input  logic [ils_pkg::POS_W-1:0]   in_pos,
  input  logic [ils_pkg::DATA_W-1:0]  in_value,
  output ils_pkg::res_t               res,
  input  logic                        res_room,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [ils_pkg::DATA_W-1:0]  ram_wdata,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_raddr,
  input  logic [ils_pkg::DATA_W-1:0]  ram_rdata
);

  import ils_pkg::*;

  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_WRITE = 6'b000100,
    S_PUT   = 6'b001000,
    S_FETCH = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t              state, state_next;
  logic [MODE_W-1:0]   op, op_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       count, count_next;
  logic [DATA_W-1:0]   val, val_next;
  logic                res_ok, res_ok_next;
  logic                res_last, res_last_next;
  logic                res_hit, res_hit_next;
  logic                res_miss, res_miss_next;

  logic [CW-1:0]       nbr;
  logic                more;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;
  logic                full;

  // Shared index unit: one add/subtract and one compare drive every walk
  assign nbr  = (op == MODE_INS_HEAD) ? idx - CW'(1) : idx + CW'(1);
  assign more = (op == MODE_INS_HEAD) ? (idx != '0) : (nbr < count);

  assign pos_x = XW'(in_pos);
  assign cnt_x = XW'(count);
  assign full  = (count == CW'(CAPACITY));

  assign in_ready  = (state == S_IDLE);
  assign res.valid = (state == S_EMIT);
  assign res.ok    = res_ok;
  assign res.last  = res_last;
  assign res.value = res_hit ? ram_rdata : (res_miss ? '1 : '0);

  always_comb begin
    state_next    = state;
    op_next       = op;
    idx_next      = idx;
    count_next    = count;
    val_next      = val;
    res_ok_next   = res_ok;
    res_last_next = res_last;
    res_hit_next  = res_hit;
    res_miss_next = res_miss;
    ram_we        = 1'b0;
    ram_waddr     = AW'(idx);
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = AW'(idx);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next       = in_mode;
          val_next      = in_value;
          res_ok_next   = 1'b0;
          res_last_next = 1'b1;
          res_hit_next  = 1'b0;
          res_miss_next = 1'b0;
          case (in_mode)
            MODE_GET: begin
              if (pos_x < cnt_x) begin
                idx_next   = CW'(pos_x);
                state_next = S_FETCH;
              end else begin
                res_miss_next = 1'b1;
                state_next    = S_EMIT;
              end
            end
            MODE_INS_HEAD: begin
              idx_next   = count;
              state_next = full ? S_EMIT : S_READ;
            end
            MODE_INS_TAIL: begin
              idx_next   = count;
              state_next = full ? S_EMIT : S_PUT;
            end
            MODE_REMOVE: begin
              if (pos_x < cnt_x) begin
                idx_next   = CW'(pos_x);
                state_next = S_READ;
              end else begin
                state_next = S_EMIT;
              end
            end
            MODE_DUMP: begin
              idx_next = '0;
              if (count != '0) begin
                state_next = S_FETCH;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        if (more) begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(nbr);
          state_next = S_WRITE;
        end else if (op == MODE_INS_HEAD) begin
          state_next = S_PUT;
        end else begin
          count_next  = count - CW'(1);
          res_ok_next = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_WRITE: begin
        ram_we     = 1'b1;
        idx_next   = nbr;
        state_next = S_READ;
      end
      S_PUT: begin
        ram_we      = 1'b1;
        ram_wdata   = val;
        count_next  = count + CW'(1);
        res_ok_next = 1'b1;
        state_next  = S_EMIT;
      end
      S_FETCH: begin
        ram_re        = 1'b1;
        res_hit_next  = 1'b1;
        res_ok_next   = 1'b1;
        res_last_next = (op == MODE_GET) || (nbr == count);
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (res_room) begin
          if (op == MODE_DUMP && !res_last) begin
            idx_next   = nbr;
            state_next = S_FETCH;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    op       <= op_next;
    idx      <= idx_next;
    val      <= val_next;
    res_ok   <= res_ok_next;
    res_last <= res_last_next;
    res_hit  <= res_hit_next;
    res_miss <= res_miss_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CW'(1)) || (count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CW'(ram_waddr) <= count))
    else $error("store write beyond the end of the list");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !in_ready)
    else $error("new request taken while a result is pending");

endmodule

@@ rtl/indexed_list_store.sv @@
`timescale 1ns / 1ps

// Ordered list of signed 32-bit values kept packed in list order in a
// CAPACITY-entry RAM (index 0 is the head). One request on the slave stream
// selects an operation by tuser: get, insert at head, insert at tail, remove,
// or dump. Get, insert and remove return exactly one result with tlast set;
// dump returns one result per stored value, tlast on the final one, and
// nothing for an empty list; unused codes return nothing. The block takes
// one request at a time and drops tready until the request is finished.
// One registered RAM read port, one RAM write port and one shared index
// adder/compare do all the walking; each moved entry is read, then written
// one place over. Insert at head shifts every entry up, remove shifts the
// entries above the position down, and dump reads each value in turn;
// results also wait while the master side holds tready low. A
// finished result sits in an output register, so the sequencer is released
// as soon as that register can take it. No clearing pass runs after reset:
// entries are only read below the current count.
module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] position, [39:8] item_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] result_value
  output logic        m_axis_tuser,   // [0] ok
  output logic        m_axis_tlast
);

  import ils_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  res_t              res;
  logic              res_room;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Value store; read data is registered and held while re is low
  ils_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Operation sequencer with the shared index unit
  ils_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_mode   (s_axis_tuser),
    .in_pos    (s_axis_tdata[POS_W-1:0]),
    .in_value  (s_axis_tdata[POS_W +: DATA_W]),
    .res       (res),
    .res_room  (res_room),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Output register: take a new result whenever the slot is empty or drains
  assign res_room = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_room) begin
      m_axis_tvalid <= res.valid;
    end
    if (res_room && res.valid) begin
      m_axis_tdata <= res.value;
      m_axis_tuser <= res.ok;
      m_axis_tlast <= res.last;
    end
  end

endmodule
